@@ rtl/lts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Shared constants, codes and types of the slot ring, the head unit and the
// remainder unit.
// ----------------------------------------------------------------------------
package lts_pkg;

  // Size of the slot table.
  localparam int SlotCount = 64;
  localparam int IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // Transaction field widths.
  localparam int OpW     = 2;
  localparam int SlotW   = 6;
  localparam int NiceW   = 8;
  localparam int RandW   = 16;
  localparam int StatusW = 2;

  // Ticket arithmetic.
  localparam int TicketW          = 7;
  localparam int StartTicketsInt  = 20;
  localparam int TicketCapInt     = 100;
  localparam int TotalMaxInt      = SlotCount * TicketCapInt;
  localparam int TotalW           = $clog2(TotalMaxInt + 1);
  localparam int CmpW             = (IdxW > SlotW) ? IdxW : SlotW;

  localparam logic [TicketW-1:0] StartTickets = TicketW'(StartTicketsInt);
  localparam logic [TicketW-1:0] TicketCap    = TicketW'(TicketCapInt);
  // A nice value above this jumps straight to the cap.
  localparam logic [NiceW-1:0]   NiceBypass   = NiceW'(TicketCapInt - StartTicketsInt);

  typedef enum logic [OpW-1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_NICE   = 2'd2,
    OP_EXPIRE = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_SLOT_ERR   = 2'd1,
    ST_NO_TICKETS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT_DIV,
    S_DRAW,
    S_DONE
  } state_e;

  // State of one process slot.
  typedef struct packed {
    logic               active;
    logic [TicketW-1:0] tickets;
    logic               winner;
  } slot_t;

  // Control from the sequencer to the head unit.
  typedef struct packed {
    logic              scan;
    logic              draw;
    op_e               op;
    logic              target_hit;
    logic              demote_hit;
    logic              walk_on;
    logic [NiceW-1:0]  nice;
    logic [TotalW-1:0] left;
  } head_ctl_t;

  // Results from the head unit back to the sequencer.
  typedef struct packed {
    slot_t             nxt;
    logic              apply;
    logic              win;
    logic [TotalW-1:0] left;
  } head_res_t;

endpackage : lts_pkg
`default_nettype wire

@@ rtl/lts_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel that carries one scheduler operation per transaction.
// ----------------------------------------------------------------------------
interface lts_req_if;
  logic                      valid;
  logic                      ready;
  logic [lts_pkg::OpW-1:0]   operation;
  logic [lts_pkg::SlotW-1:0] slot;
  logic [lts_pkg::NiceW-1:0] nice_value;
  logic [lts_pkg::RandW-1:0] random_value;

  modport source (
    output valid, operation, slot, nice_value, random_value,
    input  ready
  );

  modport sink (
    input  valid, operation, slot, nice_value, random_value,
    output ready
  );
endinterface : lts_req_if
`default_nettype wire

@@ rtl/lts_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel that carries one scheduler result per transaction.
// ----------------------------------------------------------------------------
interface lts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lts_pkg::StatusW-1:0] status;
  logic                        winner_valid;
  logic [lts_pkg::SlotW-1:0]   winner_slot;
  logic [lts_pkg::SlotW-1:0]   demoted_slot;

  modport source (
    output valid, status, winner_valid, winner_slot, demoted_slot,
    input  ready
  );

  modport sink (
    input  valid, status, winner_valid, winner_slot, demoted_slot,
    output ready
  );
endinterface : lts_rsp_if
`default_nettype wire

@@ rtl/lts_slot_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot ring cell
// Holds the state of one process slot and takes its neighbor's state on
// every shift cycle of the ring.
// ----------------------------------------------------------------------------
module lts_slot_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           shift_i,
  input  wire lts_pkg::slot_t cell_i,
  output lts_pkg::slot_t      cell_o
);
  import lts_pkg::*;

  slot_t cell_q, cell_d;

  // Take the neighbor's slot state while the ring rotates.
  always_comb begin
    cell_d = cell_q;
    if (shift_i) begin
      cell_d = cell_i;
    end
  end

  // Slots come out of reset free, with no tickets, in the loser queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule : lts_slot_cell
`default_nettype wire

@@ rtl/lts_head_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot ring head unit
// Applies start, stop and nice updates to the slot at the head of the ring,
// and performs the demotion and the ticket walk of a draw.
// ----------------------------------------------------------------------------
module lts_head_unit (
  input  wire lts_pkg::slot_t     cur_i,
  input  wire lts_pkg::head_ctl_t ctl_i,
  output lts_pkg::head_res_t      res_o
);
  import lts_pkg::*;

  logic [TicketW+1:0] nice_sum;
  logic [TicketW-1:0] nice_tickets;
  logic [TotalW-1:0]  cur_total;

  // New ticket count of a nice operation, capped.
  always_comb begin
    nice_sum = {2'b00, cur_i.tickets} + {{(TicketW + 2 - NiceW){1'b0}}, ctl_i.nice};
    if (ctl_i.nice > NiceBypass) begin
      nice_tickets = TicketCap;
    end else if (nice_sum > (TicketW + 2)'(TicketCapInt)) begin
      nice_tickets = TicketCap;
    end else begin
      nice_tickets = nice_sum[TicketW-1:0];
    end
  end

  assign cur_total = TotalW'(cur_i.tickets);

  // Slot update and draw step for the slot at the head.
  always_comb begin
    res_o.nxt   = cur_i;
    res_o.apply = 1'b0;
    res_o.win   = 1'b0;
    res_o.left  = ctl_i.left;
    if (ctl_i.scan && ctl_i.target_hit) begin
      unique case (ctl_i.op)
        OP_START: begin
          if (!cur_i.active) begin
            res_o.nxt.active  = 1'b1;
            res_o.nxt.tickets = StartTickets;
            res_o.nxt.winner  = 1'b0;
            res_o.apply       = 1'b1;
          end
        end
        OP_STOP: begin
          if (cur_i.active) begin
            res_o.nxt   = '0;
            res_o.apply = 1'b1;
          end
        end
        OP_NICE: begin
          if (cur_i.active) begin
            res_o.nxt.tickets = nice_tickets;
            res_o.apply       = 1'b1;
          end
        end
        OP_EXPIRE: begin
          res_o.nxt = cur_i;
        end
      endcase
    end
    if (ctl_i.draw) begin
      // Demotion comes first, so that a slot that wins again stays a winner.
      if (ctl_i.demote_hit) begin
        res_o.nxt.winner = 1'b0;
      end
      if (ctl_i.walk_on && cur_i.active) begin
        if (ctl_i.left < cur_total) begin
          res_o.win        = 1'b1;
          res_o.nxt.winner = 1'b1;
        end else begin
          res_o.left = ctl_i.left - cur_total;
        end
      end
    end
  end

endmodule : lts_head_unit
`default_nettype wire

@@ rtl/lts_mod_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket remainder unit
// Restoring remainder of the random number by the ticket total, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module lts_mod_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lts_pkg::RandW-1:0]   dividend_i,
  input  wire logic [lts_pkg::TotalW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [lts_pkg::TotalW-1:0]       rem_o
);
  import lts_pkg::*;

  localparam int CntW = $clog2(RandW + 1);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RandW-1:0]  dvd_q, dvd_d;
  logic [TotalW-1:0] dsr_q, dsr_d;
  logic [TotalW-1:0] rem_q, rem_d;
  logic [TotalW:0]   trial;
  logic [TotalW:0]   diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, dvd_q[RandW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RandW);
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[TotalW-1:0];
      end else begin
        rem_d = trial[TotalW-1:0];
      end
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and partial remainder.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = !busy_q;
  assign rem_o  = rem_q;

endmodule : lts_mod_unit
`default_nettype wire

@@ rtl/lottery_ticket_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lottery ticket scheduler
// Lottery scheduling over a ring of process slot cells that rotates past a
// single head unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction: start, stop or nice of a
//   slot, or a quantum expiry that demotes a slot and draws a new winner.
//   rsp_o returns exactly one result per request, in request order.
//   The slot states sit in a ring of SlotCount cells. An operation rotates
//   the ring once past the head unit, which updates the slot it targets.
//   A quantum expiry on an active slot rotates it a second time to demote
//   and walk the tickets; the remainder of the random number by the ticket
//   total is formed bit-serially during the first rotation.
//   One request is in work at a time: a new request is accepted only once
//   the result of the last one has entered the result register.
//   Reset frees all slots and clears the ticket total and the last winner
//   at once; no clearing pass is needed.
//   The result register holds a result while the receiver stalls; the next
//   request is still accepted and worked on, and its result waits until the
//   register is free.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lts_req_if.sink   req_i,
  lts_rsp_if.source rsp_o
);
  import lts_pkg::*;

  state_e             state_q, state_d;
  logic [IdxW-1:0]    pos_q, pos_d;
  op_e                op_q, op_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [NiceW-1:0]   nice_q, nice_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [SlotW-1:0]   lastw_q, lastw_d;
  logic               hit_act_q, hit_act_d;
  logic               hit_win_q, hit_win_d;
  logic               applied_q, applied_d;
  logic               walk_en_q, walk_en_d;
  logic               found_q, found_d;
  logic [SlotW-1:0]   wslot_q, wslot_d;
  logic [SlotW-1:0]   dslot_q, dslot_d;
  logic [TotalW-1:0]  left_q, left_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic               out_wvalid_q, out_wvalid_d;
  logic [SlotW-1:0]   out_wslot_q, out_wslot_d;
  logic [SlotW-1:0]   out_dslot_q, out_dslot_d;

  logic               req_accept;
  logic               shift_en;
  logic               pos_last;
  logic               target_hit;
  logic               hit_act_now;
  logic               hit_win_now;
  logic               out_free;
  logic               div_done;
  logic [TotalW-1:0]  div_rem;
  status_e            result_status;
  head_ctl_t          head_ctl;
  head_res_t          head_res;
  slot_t              cells [SlotCount];

  // Ring of slot cells; the head unit output closes the ring.
  for (genvar k = 0; k < SlotCount; k++) begin : g_ring
    if (k == SlotCount - 1) begin : g_tail
      lts_slot_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_en),
        .cell_i  (head_res.nxt),
        .cell_o  (cells[k])
      );
    end else begin : g_body
      lts_slot_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift_en),
        .cell_i  (cells[k+1]),
        .cell_o  (cells[k])
      );
    end
  end

  lts_head_unit u_head (
    .cur_i (cells[0]),
    .ctl_i (head_ctl),
    .res_o (head_res)
  );

  lts_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_accept),
    .dividend_i (req_i.random_value),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Ring position and slot matching.
  assign pos_last    = (pos_q == IdxW'(SlotCount - 1));
  assign target_hit  = (CmpW'(pos_q) == CmpW'(slot_q));
  assign hit_act_now = hit_act_q | (target_hit & cells[0].active);
  assign hit_win_now = hit_win_q | (target_hit & cells[0].winner);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pos_last) begin
          if (op_q == OP_EXPIRE && hit_act_now) begin
            state_d = S_WAIT_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WAIT_DIV: begin
        if (div_done) begin
          state_d = S_DRAW;
        end
      end
      S_DRAW: begin
        if (pos_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State outputs: handshake, ring shift and head unit control.
  always_comb begin
    req_i.ready         = (state_q == S_IDLE);
    shift_en            = (state_q == S_SCAN) || (state_q == S_DRAW);
    head_ctl.scan       = (state_q == S_SCAN);
    head_ctl.draw       = (state_q == S_DRAW);
    head_ctl.op         = op_q;
    head_ctl.target_hit = target_hit;
    head_ctl.demote_hit = (CmpW'(pos_q) == CmpW'(dslot_q));
    head_ctl.walk_on    = walk_en_q && !found_q;
    head_ctl.nice       = nice_q;
    head_ctl.left       = left_q;
  end

  // Result status of the finished operation.
  always_comb begin
    if (op_q == OP_EXPIRE) begin
      if (!hit_act_q) begin
        result_status = ST_SLOT_ERR;
      end else if (!walk_en_q) begin
        result_status = ST_NO_TICKETS;
      end else begin
        result_status = ST_OK;
      end
    end else if (applied_q) begin
      result_status = ST_OK;
    end else begin
      result_status = ST_SLOT_ERR;
    end
  end

  // Datapath registers of the sequencer.
  always_comb begin
    pos_d        = pos_q;
    op_d         = op_q;
    slot_d       = slot_q;
    nice_d       = nice_q;
    total_d      = total_q;
    lastw_d      = lastw_q;
    hit_act_d    = hit_act_q;
    hit_win_d    = hit_win_q;
    applied_d    = applied_q;
    walk_en_d    = walk_en_q;
    found_d      = found_q;
    wslot_d      = wslot_q;
    dslot_d      = dslot_q;
    left_d       = left_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_wvalid_d = out_wvalid_q;
    out_wslot_d  = out_wslot_q;
    out_dslot_d  = out_dslot_q;

    if (shift_en) begin
      pos_d = pos_last ? '0 : pos_q + IdxW'(1);
    end

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          op_d      = op_e'(req_i.operation);
          slot_d    = req_i.slot;
          nice_d    = req_i.nice_value;
          hit_act_d = 1'b0;
          hit_win_d = 1'b0;
          applied_d = 1'b0;
          found_d   = 1'b0;
        end
      end
      S_SCAN: begin
        if (target_hit) begin
          hit_act_d = cells[0].active;
          hit_win_d = cells[0].winner;
        end
        // Keep the total equal to the sum over the slots in use.
        if (head_res.apply) begin
          applied_d = 1'b1;
          total_d   = total_q - TotalW'(cells[0].tickets) + TotalW'(head_res.nxt.tickets);
        end
        if (pos_last) begin
          walk_en_d = (total_q != '0);
          dslot_d   = hit_win_now ? slot_q : lastw_q;
        end
      end
      S_WAIT_DIV: begin
        left_d = div_rem;
      end
      S_DRAW: begin
        left_d = head_res.left;
        if (head_res.win) begin
          found_d = 1'b1;
          wslot_d = SlotW'(pos_q);
          lastw_d = SlotW'(pos_q);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = result_status;
          out_wvalid_d = (op_q == OP_EXPIRE) && found_q;
          out_wslot_d  = ((op_q == OP_EXPIRE) && found_q) ? wslot_q : '0;
          out_dslot_d  = ((op_q == OP_EXPIRE) && hit_act_q) ? dslot_q : '0;
        end
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      total_q     <= '0;
      lastw_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      total_q     <= total_d;
      lastw_q     <= lastw_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operation operands, draw bookkeeping and result payload.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    nice_q       <= nice_d;
    hit_act_q    <= hit_act_d;
    hit_win_q    <= hit_win_d;
    applied_q    <= applied_d;
    walk_en_q    <= walk_en_d;
    found_q      <= found_d;
    wslot_q      <= wslot_d;
    dslot_q      <= dslot_d;
    left_q       <= left_d;
    out_status_q <= out_status_d;
    out_wvalid_q <= out_wvalid_d;
    out_wslot_q  <= out_wslot_d;
    out_dslot_q  <= out_dslot_d;
  end

  // Response channel.
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.winner_valid = out_wvalid_q;
  assign rsp_o.winner_slot  = out_wslot_q;
  assign rsp_o.demoted_slot = out_dslot_q;

  // The ring is back in index order whenever no operation is in work.
  a_ring_aligned: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> pos_q == '0
  ) else $error("slot ring not aligned while idle");

  // The ticket total never exceeds every slot at the cap.
  a_total_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotalW'(TotalMaxInt)
  ) else $error("ticket total out of range");

  // A winner is only reported with an ok status.
  a_winner_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.winner_valid |-> rsp_o.status == ST_OK
  ) else $error("winner reported with error status");

  // Only one slot wins per draw: once found, the walk stays finished.
  a_single_win: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAW && found_q |-> !head_res.win
  ) else $error("second winner in one draw");

endmodule : lottery_ticket_scheduler
`default_nettype wire

@@ verif/tb_lottery_ticket_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery ticket scheduler testbench
// Drives start, stop, nice and quantum-expiry transactions into the scheduler.
// A slot-table model in the bench predicts each response, and every response
// is compared field by field in order. A directed opening is followed by
// constrained-by-hand random traffic under four back-pressure phases.
// ----------------------------------------------------------------------------
module tb_lottery_ticket_scheduler;
  import lts_pkg::*;

  localparam int RandomItems = 1226;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 2 * SlotCount + 16;
  localparam int MaxShown    = 10;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [NiceW-1:0] nice;
    logic [RandW-1:0] rnd;
  } sched_req_t;

  typedef struct packed {
    status_e          status;
    logic             winner_valid;
    logic [SlotW-1:0] winner_slot;
    logic [SlotW-1:0] demoted_slot;
  } sched_rsp_t;

  logic clk_i;
  logic rst_ni;

  lts_req_if req_if ();
  lts_rsp_if rsp_if ();

  lottery_ticket_scheduler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Transactions waiting to be sent and responses waiting to arrive.
  sched_req_t pending_q[$];
  sched_rsp_t expected_q[$];

  // Slot table as the scheduler should hold it.
  bit               slot_on  [SlotCount];
  bit [TicketW-1:0] slot_tix [SlotCount];
  bit               slot_win [SlotCount];
  int unsigned      tix_total;
  bit [SlotW-1:0]   last_win;

  // Slots the stimulus generator believes are in use.
  bit gen_used [SlotCount];
  int gen_used_cnt;

  int total_items;
  int accepted_cnt;
  int checked_cnt;
  int err_cnt;
  int shown_cnt;
  int cycle_cnt;
  int op_cnt [4];
  int win_cnt;
  int reject_cnt;

  // Idle percentages per phase: none, sender, receiver, both.
  int send_idle_pct [4] = '{0, 73, 0, 24};
  int recv_idle_pct [4] = '{0, 0, 73, 24};

  sched_req_t acc_item;
  sched_rsp_t got_rsp;
  sched_rsp_t want_rsp;
  sched_req_t nxt_item;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_phase();
    int p;
    p = (total_items == 0) ? 0 : (accepted_cnt * 4) / total_items;
    return (p > 3) ? 3 : p;
  endfunction

  // Predict the response of one transaction and update the slot table.
  function automatic sched_rsp_t schedule_step(sched_req_t r);
    sched_rsp_t  res;
    int unsigned s;
    int unsigned old_t;
    int unsigned new_t;
    int unsigned left;
    res.status       = ST_OK;
    res.winner_valid = 1'b0;
    res.winner_slot  = '0;
    res.demoted_slot = '0;
    s = r.slot;
    op_cnt[r.op]++;
    if (s >= SlotCount || (r.op == OP_START) == slot_on[s]) begin
      // Start of a used slot, or any other operation on a free slot.
      res.status = ST_SLOT_ERR;
      reject_cnt++;
      return res;
    end
    case (r.op)
      OP_START: begin
        slot_on[s]  = 1'b1;
        slot_tix[s] = StartTickets;
        slot_win[s] = 1'b0;
        tix_total  += StartTicketsInt;
      end
      OP_STOP: begin
        slot_on[s]  = 1'b0;
        tix_total  -= slot_tix[s];
        slot_tix[s] = '0;
        slot_win[s] = 1'b0;
      end
      OP_NICE: begin
        old_t = slot_tix[s];
        if (r.nice > NiceBypass) begin
          new_t = TicketCapInt;
        end else begin
          new_t = old_t + r.nice;
          if (new_t > TicketCapInt) new_t = TicketCapInt;
        end
        slot_tix[s] = TicketW'(new_t);
        tix_total   = tix_total - old_t + new_t;
      end
      default: begin
        // Demote the reporting slot if it won, otherwise the last winner.
        if (slot_win[s]) begin
          slot_win[s]      = 1'b0;
          res.demoted_slot = r.slot;
        end else begin
          slot_win[last_win] = 1'b0;
          res.demoted_slot   = last_win;
        end
        if (tix_total == 0) begin
          res.status = ST_NO_TICKETS;
        end else begin
          left = r.rnd % tix_total;
          for (int i = 0; i < SlotCount; i++) begin
            if (!res.winner_valid && slot_on[i]) begin
              if (left < slot_tix[i]) begin
                slot_win[i]      = 1'b1;
                last_win         = SlotW'(i);
                res.winner_valid = 1'b1;
                res.winner_slot  = SlotW'(i);
              end else begin
                left -= slot_tix[i];
              end
            end
          end
          if (res.winner_valid) win_cnt++;
        end
      end
    endcase
    return res;
  endfunction

  // Pick a random slot that is in use (or free); any slot if none fits.
  function automatic int pick_slot(bit want_used);
    int cand[$];
    for (int i = 0; i < SlotCount; i++) begin
      if (gen_used[i] == want_used) cand.push_back(i);
    end
    if (cand.size() == 0) return $urandom_range(SlotCount - 1);
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  task automatic add_item(op_e op, int slot, int nice, int rnd);
    sched_req_t it;
    it.op   = op;
    it.slot = SlotW'(slot);
    it.nice = NiceW'(nice);
    it.rnd  = RandW'(rnd);
    // Track in-use slots so that random traffic stays mostly well formed.
    if (op == OP_START && !gen_used[slot]) begin
      gen_used[slot] = 1'b1;
      gen_used_cnt++;
    end else if (op == OP_STOP && gen_used[slot]) begin
      gen_used[slot] = 1'b0;
      gen_used_cnt--;
    end
    pending_q.push_back(it);
  endtask

  task automatic build_directed();
    // Operations on free slots are rejected, then slots 0 and 63 are started.
    add_item(OP_EXPIRE, 0, 0, 0);
    add_item(OP_STOP, 63, 255, 16'hFFFF);
    add_item(OP_NICE, 5, 10, 0);
    add_item(OP_START, 0, 0, 0);
    add_item(OP_START, 63, 0, 0);
    // Start of a slot that is already in use.
    add_item(OP_START, 0, 0, 0);
    // Draws at both ends of the random range.
    add_item(OP_EXPIRE, 0, 0, 0);
    add_item(OP_EXPIRE, 63, 0, 16'hFFFF);
    add_item(OP_EXPIRE, 0, 0, 39);
    // Nice above the bypass point, exactly at it, and saturating sums.
    add_item(OP_NICE, 63, 255, 0);
    add_item(OP_NICE, 0, 80, 0);
    add_item(OP_START, 21, 0, 0);
    add_item(OP_NICE, 21, 0, 0);
    add_item(OP_NICE, 21, 79, 0);
    add_item(OP_NICE, 21, 5, 0);
    add_item(OP_EXPIRE, 63, 0, 16'hAAAA);
    add_item(OP_EXPIRE, 21, 0, 16'h5555);
    // Stop a possible winner, then demote the last winner after it left.
    add_item(OP_STOP, 63, 0, 0);
    add_item(OP_EXPIRE, 21, 0, 16'h1234);
    add_item(OP_STOP, 63, 0, 0);
    add_item(OP_STOP, 0, 0, 0);
    add_item(OP_STOP, 21, 0, 0);
    add_item(OP_EXPIRE, 42, 0, 16'hFFFF);
    add_item(OP_NICE, 42, 200, 0);
  endtask

  task automatic build_random(int count);
    int   r;
    int   start_w;
    int   stop_w;
    int   nice;
    op_e  op;
    for (int n = 0; n < count; n++) begin
      nice = ($urandom_range(1) != 0) ? $urandom_range(80) : $urandom_range(255);
      if ($urandom_range(99) < 6) begin
        // Noise: any operation on any slot.
        add_item(op_e'($urandom_range(3)), $urandom_range(SlotCount - 1), nice,
                 $urandom_range(65535));
      end else begin
        start_w = (gen_used_cnt < 8) ? 50 : ((gen_used_cnt > 48) ? 5 : 20);
        stop_w  = (gen_used_cnt > 48) ? 30 : 10;
        r = $urandom_range(99);
        if (gen_used_cnt == 0 || r < start_w) op = OP_START;
        else if (r < start_w + stop_w)     op = OP_STOP;
        else if (r < start_w + stop_w + 20) op = OP_NICE;
        else                                op = OP_EXPIRE;
        add_item(op, pick_slot(op != OP_START), nice, $urandom_range(65535));
      end
    end
  endtask

  // Request driver: holds a transaction until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.operation    <= '0;
      req_if.slot         <= '0;
      req_if.nice_value   <= '0;
      req_if.random_value <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        acc_item.op   = op_e'(req_if.operation);
        acc_item.slot = req_if.slot;
        acc_item.nice = req_if.nice_value;
        acc_item.rnd  = req_if.random_value;
        expected_q.push_back(schedule_step(acc_item));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct[idle_phase()]) begin
          nxt_item = pending_q.pop_front();
          req_if.valid        <= 1'b1;
          req_if.operation    <= nxt_item.op;
          req_if.slot         <= nxt_item.slot;
          req_if.nice_value   <= nxt_item.nice;
          req_if.random_value <= nxt_item.rnd;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each transaction with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_rsp.status       = status_e'(rsp_if.status);
        got_rsp.winner_valid = rsp_if.winner_valid;
        got_rsp.winner_slot  = rsp_if.winner_slot;
        got_rsp.demoted_slot = rsp_if.demoted_slot;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (shown_cnt < MaxShown) begin
            shown_cnt++;
            $display("[%0t] unexpected response: status=%0d win=%0d slot=%0d demoted=%0d",
                     $realtime, got_rsp.status, got_rsp.winner_valid,
                     got_rsp.winner_slot, got_rsp.demoted_slot);
          end
        end else begin
          want_rsp = expected_q.pop_front();
          checked_cnt++;
          if (got_rsp.status != want_rsp.status ||
              got_rsp.winner_valid != want_rsp.winner_valid ||
              got_rsp.winner_slot != want_rsp.winner_slot ||
              got_rsp.demoted_slot != want_rsp.demoted_slot) begin
            err_cnt++;
            if (shown_cnt < MaxShown) begin
              shown_cnt++;
              $display("[%0t] response %0d mismatch: expected status=%0d win=%0d slot=%0d demoted=%0d",
                       $realtime, checked_cnt, want_rsp.status, want_rsp.winner_valid,
                       want_rsp.winner_slot, want_rsp.demoted_slot);
              $display("%28s got      status=%0d win=%0d slot=%0d demoted=%0d", "",
                       got_rsp.status, got_rsp.winner_valid, got_rsp.winner_slot,
                       got_rsp.demoted_slot);
            end
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct[idle_phase()]);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_cnt, expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus, reset and end of test.
  initial begin
    rst_ni       = 1'b0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    err_cnt      = 0;
    shown_cnt    = 0;
    cycle_cnt    = 0;
    win_cnt      = 0;
    reject_cnt   = 0;
    tix_total    = 0;
    last_win     = '0;
    gen_used_cnt = 0;
    for (int i = 0; i < SlotCount; i++) begin
      slot_on[i]  = 1'b0;
      slot_tix[i] = '0;
      slot_win[i] = 1'b0;
      gen_used[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) op_cnt[i] = 0;
    build_directed();
    build_random(RandomItems);
    total_items = pending_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every sent transaction has been answered and checked.
    while (checked_cnt < total_items) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      err_cnt += expected_q.size();
      $display("%0d responses never arrived", expected_q.size());
    end
    $display("Sent %0d transactions (start %0d, stop %0d, nice %0d, expiry %0d), %0d rejected,",
             accepted_cnt, op_cnt[OP_START], op_cnt[OP_STOP], op_cnt[OP_NICE],
             op_cnt[OP_EXPIRE], reject_cnt);
    $display("%0d draws with a winner, %0d responses checked, %0d errors",
             win_cnt, checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule : tb_lottery_ticket_scheduler
